FILE: sv/pste_pkg.sv
// shared types, constants and register codes of the pot smoother and touch edge block
package pste_pkg;

  localparam int PAD_COUNT_DEF     = 4;
  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int PAD_INPUTS  = 4;
  localparam int GAIN_W      = 17;
  localparam int GAIN_FRAC   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
  localparam logic [15:0]       THR_RESET  = 16'd1000;
  localparam logic [GAIN_W-1:0] FAST_RESET = GAIN_W'(5243);
  localparam logic [GAIN_W-1:0] SLOW_RESET = GAIN_W'(655);
  localparam logic [6:0]        LEVEL_MAX  = 7'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_FAST_GAIN = 2'd1,
    REG_SLOW_GAIN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] pot1_sample;
    logic [11:0] pot2_sample;
    logic [15:0] pad0_reading;
    logic [15:0] pad1_reading;
    logic [15:0] pad2_reading;
    logic [15:0] pad3_reading;
    logic [3:0]  pad_read_ok;
    logic [6:0]  last_pot1_sent;
    logic [6:0]  last_pot2_sent;
  } in_word_t;

  typedef struct packed {
    logic [6:0] pot1_level;
    logic [6:0] pot2_level;
    logic [6:0] pot1_center;
    logic [6:0] pot2_center;
    logic [3:0] touch_now;
    logic [3:0] touch_rise;
    logic [3:0] touch_written;
    logic       any_change;
  } out_word_t;

  typedef struct packed {
    logic [11:0] pot1_sample;
    logic [11:0] pot2_sample;
    logic [6:0]  last_pot1_sent;
    logic [6:0]  last_pot2_sent;
    logic [3:0]  touch_now;
    logic [3:0]  touch_rise;
    logic [3:0]  touch_written;
    logic        touch_change;
  } task_t;

  typedef struct packed {
    logic [GAIN_W-1:0] fast;
    logic [GAIN_W-1:0] slow;
  } gains_t;

endpackage

FILE: sv/pot_smoother_touch_edge_top.sv
// Smooths two pot samples with fast and slow exponential averages (Q12.16, first
// word loads both) scaled to 0..127, and reports touch pad state and rising edges.
// Each word is classified by the front end in the cycle it is accepted and waits in
// a two-entry queue; the back end then picks up one word at a time and runs four
// averages one after another, each with its two products on the single shared
// multiplier, one add, a step for the scaling numerator and one reciprocal
// multiplication for the level, and loads the output register once it is free.
// Up to two words are taken ahead while the back end is busy.
// Register writes take effect at once and are meant to be done while no word is
// in flight.
module pot_smoother_touch_edge_top import pste_pkg::*; #(
  parameter int PAD_COUNT     = PAD_COUNT_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [15:0] thr_q;
  gains_t      gains_q;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  task_t       push_task, pop_task;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THR_RESET;
      gains_q.fast <= FAST_RESET;
      gains_q.slow <= SLOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: thr_q        <= cfg_data_i[15:0];
        REG_FAST_GAIN: gains_q.fast <= cfg_data_i;
        REG_SLOW_GAIN: gains_q.slow <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pste_front #(
    .PAD_COUNT (PAD_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .threshold_i  (thr_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_task_o  (push_task)
  );

  pste_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_task_i  (push_task),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_task_o   (pop_task)
  );

  pste_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gains_i     (gains_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_task_i  (pop_task),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: sv/pste_front.sv
// front end: takes input words, classifies touch pads and tracks pad state
module pste_front import pste_pkg::*; #(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  input  logic [15:0] threshold_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output task_t       push_task_o
);

  logic [PAD_COUNT-1:0] prev_q, prev_d;
  logic [15:0]          rd [PAD_INPUTS];
  logic [3:0]           now, rise, written;
  logic                 change;
  logic                 accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  assign rd[0] = in_word_i.pad0_reading;
  assign rd[1] = in_word_i.pad1_reading;
  assign rd[2] = in_word_i.pad2_reading;
  assign rd[3] = in_word_i.pad3_reading;

  always_comb begin
    logic cur;
    prev_d  = prev_q;
    now     = '0;
    rise    = '0;
    written = '0;
    change  = 1'b0;
    cur     = 1'b0;
    for (int i = 0; i < PAD_COUNT; i++) begin
      if (i < PAD_INPUTS) begin
        if (in_word_i.pad_read_ok[2'(i)]) begin
          cur              = rd[2'(i)] < threshold_i;
          written[2'(i)]   = 1'b1;
          now[2'(i)]       = cur;
          rise[2'(i)]      = cur && !prev_q[i];
          if (cur != prev_q[i]) begin
            change    = 1'b1;
            prev_d[i] = cur;
          end
        end else begin
          now[2'(i)] = prev_q[i];
        end
      end
    end
  end

  always_comb begin
    push_task_o.pot1_sample    = in_word_i.pot1_sample;
    push_task_o.pot2_sample    = in_word_i.pot2_sample;
    push_task_o.last_pot1_sent = in_word_i.last_pot1_sent;
    push_task_o.last_pot2_sent = in_word_i.last_pot2_sent;
    push_task_o.touch_now      = now;
    push_task_o.touch_rise     = rise;
    push_task_o.touch_written  = written;
    push_task_o.touch_change   = change;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (accept) begin
      prev_q <= prev_d;
    end
  end

endmodule

FILE: sv/pste_queue.sv
// two-entry queue between front end and averaging back end
module pste_queue import pste_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  task_t push_task_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output task_t pop_task_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  task_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_task_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_task_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not grow on push");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CNT_W'(QUEUE_DEPTH)) |-> wr_q == rd_q)
    else $error("queue pointers out of step with count");

endmodule

FILE: sv/pste_back.sv
// back end: shared multiplier averaging engine, level scaling and output register
module pste_back import pste_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gains_t    gains_i,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  task_t     pop_task_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int AVG_W  = SAMPLE_BITS + FRACTION_BITS;
  localparam int PROD_W = GAIN_W + AVG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int NUM_W  = SAMPLE_BITS + 9;

  localparam logic [SUM_W-1:0] HALF_GAIN  = SUM_W'(1) << (GAIN_FRAC - 1);
  localparam logic [AVG_W:0]   HALF_FRAC  = (AVG_W + 1)'(1) << (FRACTION_BITS - 1);
  localparam logic [NUM_W-1:0] FULL_SCALE = NUM_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [NUM_W-1:0] DIVISOR    = NUM_W'(2 * ((1 << SAMPLE_BITS) - 1));
  localparam logic [NUM_W-1:0] LEVEL_MUL  = NUM_W'(2 * 127);

  localparam int RCP_W   = NUM_W + 1;
  localparam int QPROD_W = NUM_W + RCP_W;
  localparam int RCP_SH  = NUM_W + $clog2(2 * ((1 << SAMPLE_BITS) - 1));
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL0 = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_ADD  = 7'b0001000,
    S_LVL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  task_t              task_q;
  logic [1:0]         idx_q;
  logic [PROD_W-1:0]  prod_q, acc_q, prod;
  logic [AVG_W-1:0]   avg_q [4];
  logic [6:0]         lvl_q [4];
  logic [NUM_W-1:0]   num_q, num;
  logic [QPROD_W-1:0] qprod;
  logic [7:0]         qt;
  logic               primed_q, out_valid_q;
  out_word_t          out_q;

  logic [SAMPLE_BITS-1:0] s_sel;
  logic [GAIN_W-1:0]      g_raw, g_sel, mul_a;
  logic [AVG_W-1:0]       mul_b, avg_cur, avg_new;
  logic [SUM_W-1:0]       sum;
  logic [AVG_W:0]         rnd;
  logic [6:0]             lvl_new;
  logic                   out_free;

  assign pop_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // operand selection for the shared multiplier
  assign s_sel   = idx_q[0] ? SAMPLE_BITS'(task_q.pot2_sample)
                            : SAMPLE_BITS'(task_q.pot1_sample);
  assign g_raw   = idx_q[1] ? gains_i.slow : gains_i.fast;
  assign g_sel   = (g_raw > GAIN_ONE) ? GAIN_ONE : g_raw;
  assign avg_cur = avg_q[idx_q];
  assign mul_a   = (state_q == S_MUL0) ? g_sel : GAIN_ONE - g_sel;
  assign mul_b   = (state_q == S_MUL0) ? {s_sel, {FRACTION_BITS{1'b0}}} : avg_cur;
  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign sum     = SUM_W'(acc_q) + SUM_W'(prod_q) + HALF_GAIN;
  assign avg_new = primed_q ? AVG_W'(sum >> GAIN_FRAC)
                            : {s_sel, {FRACTION_BITS{1'b0}}};

  assign rnd = (AVG_W + 1)'(avg_cur) + HALF_FRAC;
  assign num = NUM_W'(rnd >> FRACTION_BITS) * LEVEL_MUL + FULL_SCALE;

  // level = num / (2 * full scale) by reciprocal multiplication
  assign qprod   = QPROD_W'(num_q) * QPROD_W'(RECIP);
  assign qt      = 8'(qprod >> RCP_SH);
  assign lvl_new = (qt > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : qt[6:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (pop_valid_i) state_d = S_MUL0;
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_ADD;
      S_ADD:  state_d = S_LVL;
      S_LVL:  state_d = S_DIV;
      S_DIV:  state_d = (idx_q == 2'd3) ? S_DONE : S_MUL0;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (pop_valid_i) task_q <= pop_task_i;
      S_MUL0: prod_q <= prod;
      S_MUL1: begin
        acc_q  <= prod_q;
        prod_q <= prod;
      end
      S_ADD:  avg_q[idx_q] <= avg_new;
      S_LVL:  num_q <= num;
      S_DIV:  lvl_q[idx_q] <= lvl_new;
      S_DONE: begin
        if (out_free) begin
          out_q.pot1_level    <= lvl_q[0];
          out_q.pot2_level    <= lvl_q[1];
          out_q.pot1_center   <= lvl_q[2];
          out_q.pot2_center   <= lvl_q[3];
          out_q.touch_now     <= task_q.touch_now;
          out_q.touch_rise    <= task_q.touch_rise;
          out_q.touch_written <= task_q.touch_written;
          out_q.any_change    <= task_q.touch_change
                                 || (lvl_q[0] != task_q.last_pot1_sent)
                                 || (lvl_q[1] != task_q.last_pot2_sent);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: idx_q <= '0;
        S_DIV:  idx_q <= idx_q + 1'b1;
        default: ;
      endcase
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        primed_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> out_valid_q && state_q == S_IDLE)
    else $error("finished word not loaded into output register");

  a_primed_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    primed_q |=> primed_q)
    else $error("primed flag dropped");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LVL |=> state_q == S_DIV)
    else $error("level scaling did not follow numerator step");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_i && state_q == S_IDLE) |=> state_q == S_MUL0 && idx_q == 2'd0)
    else $error("new word did not start at first average");

endmodule

FILE: tb/tb_pot_smoother_touch_edge_top.sv
// testbench for the pot smoother and touch edge block: predicted results checked word by word
module tb_pot_smoother_touch_edge_top;
  import pste_pkg::*;

  localparam int AVG_W = SAMPLE_BITS_DEF + FRACTION_BITS_DEF;
  localparam int FRAC = FRACTION_BITS_DEF;
  localparam logic [63:0] FULL_SCALE = (64'd1 << SAMPLE_BITS_DEF) - 64'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_TICKS = 280;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_word_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_word_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pot_smoother_touch_edge_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor copy of registers and state
  logic [15:0]       thr_q = THR_RESET;
  logic [GAIN_W-1:0] fast_gain_q = FAST_RESET;
  logic [GAIN_W-1:0] slow_gain_q = SLOW_RESET;
  logic [AVG_W-1:0]  fast_avg [2];
  logic [AVG_W-1:0]  slow_avg [2];
  logic              primed = 1'b0;
  logic [3:0]        touched = 4'b0;

  logic [11:0] gen_pot [2];
  in_word_t    pending_ticks [$];
  out_word_t   expected_reports [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_pot_smoother_touch_edge_top NOT OK");
    $finish;
  end

  function automatic logic [AVG_W-1:0] ema_next(logic [AVG_W-1:0] avg, logic [11:0] x,
                                                logic [GAIN_W-1:0] gain);
    logic [63:0] g, acc;
    g = (gain > GAIN_ONE) ? 64'(GAIN_ONE) : 64'(gain);
    acc = g * (64'(x) << FRAC) + (64'(GAIN_ONE) - g) * 64'(avg) + (64'(GAIN_ONE) >> 1);
    acc = acc >> GAIN_FRAC;
    return acc[AVG_W-1:0];
  endfunction

  function automatic logic [6:0] level_of(logic [AVG_W-1:0] avg);
    logic [63:0] v, lvl;
    v = (64'(avg) + (64'd1 << (FRAC - 1))) >> FRAC;
    lvl = (2 * v * 127 + FULL_SCALE) / (2 * FULL_SCALE);
    return (lvl > 64'(LEVEL_MAX)) ? LEVEL_MAX : lvl[6:0];
  endfunction

  function automatic out_word_t smooth_and_detect(in_word_t w);
    out_word_t   r;
    logic [11:0] pot [2];
    logic [6:0]  sent [2];
    logic [6:0]  lvl [2];
    logic [15:0] rd [4];
    logic        cur;
    int          p, i;
    r = '0;
    pot[0] = w.pot1_sample;
    pot[1] = w.pot2_sample;
    sent[0] = w.last_pot1_sent;
    sent[1] = w.last_pot2_sent;
    rd[0] = w.pad0_reading;
    rd[1] = w.pad1_reading;
    rd[2] = w.pad2_reading;
    rd[3] = w.pad3_reading;
    for (p = 0; p < 2; p++) begin
      if (!primed) begin
        fast_avg[p] = {pot[p], {FRAC{1'b0}}};
        slow_avg[p] = {pot[p], {FRAC{1'b0}}};
      end else begin
        fast_avg[p] = ema_next(fast_avg[p], pot[p], fast_gain_q);
        slow_avg[p] = ema_next(slow_avg[p], pot[p], slow_gain_q);
      end
      lvl[p] = level_of(fast_avg[p]);
      if (lvl[p] != sent[p]) r.any_change = 1'b1;
    end
    primed = 1'b1;
    r.pot1_level = lvl[0];
    r.pot2_level = lvl[1];
    r.pot1_center = level_of(slow_avg[0]);
    r.pot2_center = level_of(slow_avg[1]);
    for (i = 0; i < PAD_INPUTS; i++) begin
      if (w.pad_read_ok[i]) begin
        cur = rd[i] < thr_q;
        r.touch_written[i] = 1'b1;
        r.touch_now[i] = cur;
        r.touch_rise[i] = cur & ~touched[i];
        if (cur != touched[i]) begin
          r.any_change = 1'b1;
          touched[i] = cur;
        end
      end else begin
        r.touch_now[i] = touched[i];
      end
    end
    return r;
  endfunction

  function automatic in_word_t make_tick(logic [11:0] p1, logic [11:0] p2, logic [15:0] r0,
                                         logic [15:0] r1, logic [15:0] r2, logic [15:0] r3,
                                         logic [3:0] ok, logic [6:0] s1, logic [6:0] s2);
    in_word_t w;
    w.pot1_sample = p1;
    w.pot2_sample = p2;
    w.pad0_reading = r0;
    w.pad1_reading = r1;
    w.pad2_reading = r2;
    w.pad3_reading = r3;
    w.pad_read_ok = ok;
    w.last_pot1_sent = s1;
    w.last_pot2_sent = s2;
    return w;
  endfunction

  function automatic logic [15:0] pick_reading();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return (thr_q == 16'd0) ? 16'd0 : thr_q - 16'd1;
      2: return thr_q;
      default: return 16'($urandom_range(32'(thr_q)));
    endcase
  endfunction

  // mostly slow drift so the averages settle, with jumps and rails mixed in
  function automatic logic [11:0] pick_pot(logic [11:0] last);
    int t;
    case ($urandom_range(9))
      0, 1: return 12'($urandom);
      2: return 12'd0;
      3: return 12'hFFF;
      default: begin
        t = int'(last) + int'($urandom_range(8)) - 4;
        if (t < 0) t = 0;
        if (t > 4095) t = 4095;
        return 12'(t);
      end
    endcase
  endfunction

  function automatic logic [6:0] pick_sent(logic [11:0] x);
    case ($urandom_range(4))
      0: return 7'($urandom);
      1: return $urandom_range(1) ? LEVEL_MAX : 7'd0;
      default: return level_of({x, {FRAC{1'b0}}});
    endcase
  endfunction

  function automatic in_word_t random_tick();
    in_word_t w;
    w.pot1_sample = pick_pot(gen_pot[0]);
    w.pot2_sample = pick_pot(gen_pot[1]);
    gen_pot[0] = w.pot1_sample;
    gen_pot[1] = w.pot2_sample;
    w.pad0_reading = pick_reading();
    w.pad1_reading = pick_reading();
    w.pad2_reading = pick_reading();
    w.pad3_reading = pick_reading();
    w.pad_read_ok = $urandom_range(1) ? 4'hF : 4'($urandom);
    w.last_pot1_sent = pick_sent(w.pot1_sample);
    w.last_pot2_sent = pick_sent(w.pot2_sample);
    return w;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_THRESHOLD: thr_q = data[15:0];
      REG_FAST_GAIN: fast_gain_q = data;
      REG_SLOW_GAIN: slow_gain_q = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || expected_reports.size() != 0);
  endtask

  task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) expected_reports.push_back(smooth_and_detect(in_word_i));
    if (!in_valid_i || in_ready_o) begin
      if (rst_ni && pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word_i <= pending_ticks.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %h", out_word_o);
      end else begin
        want = expected_reports.pop_front();
        check_field("pot1_level", want.pot1_level, out_word_o.pot1_level);
        check_field("pot2_level", want.pot2_level, out_word_o.pot2_level);
        check_field("pot1_center", want.pot1_center, out_word_o.pot1_center);
        check_field("pot2_center", want.pot2_center, out_word_o.pot2_center);
        check_field("touch_now", 7'(want.touch_now), 7'(out_word_o.touch_now));
        check_field("touch_rise", 7'(want.touch_rise), 7'(out_word_o.touch_rise));
        check_field("touch_written", 7'(want.touch_written), 7'(out_word_o.touch_written));
        check_field("any_change", 7'(want.any_change), 7'(out_word_o.any_change));
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    gen_pot[0] = 12'd0;
    gen_pot[1] = 12'd0;
    send_idle_pct = 21;
    recv_idle_pct = 57;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first word loads the averages, then rails, failed reads and threshold edges
    pending_ticks.push_back(make_tick(12'hFFF, 12'h000, 16'd0, 16'hFFFF, 16'd999, 16'd1000,
                                      4'hF, 7'd127, 7'd0));
    pending_ticks.push_back(make_tick(12'hFFF, 12'h000, 16'd0, 16'hFFFF, 16'd999, 16'd1000,
                                      4'hF, 7'd127, 7'd0));
    pending_ticks.push_back(make_tick(12'h000, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      4'hF, 7'd0, 7'd0));
    pending_ticks.push_back(make_tick(12'h000, 12'hFFF, 16'd0, 16'd0, 16'd0, 16'd0,
                                      4'h0, 7'd0, 7'd0));
    pending_ticks.push_back(make_tick(12'h000, 12'hFFF, 16'd0, 16'd0, 16'd0, 16'd0,
                                      4'hF, 7'd0, 7'd127));
    pending_ticks.push_back(make_tick(12'h000, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      4'h0, 7'd0, 7'd127));
    pending_ticks.push_back(make_tick(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      4'h5, 7'd127, 7'd127));
    pending_ticks.push_back(make_tick(12'd2048, 12'd2047, 16'd1, 16'd998, 16'd1001, 16'hFFFE,
                                      4'hA, 7'd64, 7'd63));
    pending_ticks.push_back(make_tick(12'd1, 12'd4094, 16'd999, 16'd1000, 16'd0, 16'hFFFF,
                                      4'hF, 7'd0, 7'd127));
    pending_ticks.push_back(make_tick(12'hFFF, 12'h000, 16'hAAAA, 16'h5555, 16'd0, 16'd0,
                                      4'h3, 7'd127, 7'd127));
    pending_ticks.push_back(make_tick(12'hFFF, 12'h000, 16'd0, 16'd0, 16'd0, 16'd0,
                                      4'hC, 7'd0, 7'd0));
    pending_ticks.push_back(make_tick(12'd2047, 12'd2048, 16'd1000, 16'd1000, 16'd1000,
                                      16'd1000, 4'hF, 7'd64, 7'd64));
    wait_drained();

    for (int s = 0; s < 6; s++) begin
      case (s)
        0: begin
          cfg_write(REG_THRESHOLD, 17'd32768);
          cfg_write(REG_FAST_GAIN, 17'd5243);
          cfg_write(REG_SLOW_GAIN, 17'd655);
        end
        1: begin
          cfg_write(REG_THRESHOLD, 17'd0);
          cfg_write(REG_FAST_GAIN, 17'd65536);
          cfg_write(REG_SLOW_GAIN, 17'd0);
        end
        2: begin
          cfg_write(REG_THRESHOLD, 17'd65535);
          cfg_write(REG_FAST_GAIN, 17'h1FFFF);
          cfg_write(REG_SLOW_GAIN, 17'd1);
          send_idle_pct = 57;
          recv_idle_pct = 21;
        end
        3: begin
          cfg_write(REG_THRESHOLD, 17'd20000);
          cfg_write(REG_FAST_GAIN, 17'd0);
          cfg_write(REG_SLOW_GAIN, 17'd65535);
        end
        4: begin
          cfg_write(REG_THRESHOLD, 17'd40000);
          cfg_write(REG_FAST_GAIN, 17'd30000);
          cfg_write(REG_SLOW_GAIN, 17'd100000);
          cfg_write(REG_SPARE, 17'h1FFFF);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        default: begin
          cfg_write(REG_THRESHOLD, 17'd1000);
          cfg_write(REG_FAST_GAIN, 17'd5243);
          cfg_write(REG_SLOW_GAIN, 17'd655);
        end
      endcase
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      repeat (RANDOM_TICKS) pending_ticks.push_back(random_tick());
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("tb_pot_smoother_touch_edge_top OK");
    end else begin
      $display("tb_pot_smoother_touch_edge_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pste_pkg.sv
sv/pste_front.sv
sv/pste_queue.sv
sv/pste_back.sv
sv/pot_smoother_touch_edge_top.sv
tb/tb_pot_smoother_touch_edge_top.sv
